[hw/rtl/shuffled_lehmer_uniform_generator_defines.svh]
// ============================================================================
// Assertion macros for the shuffled Lehmer uniform generator
// Shared property wrappers. Each one samples on clk and is disabled while
// rst_n is low.
// ============================================================================
`ifndef SHUFFLED_LEHMER_UNIFORM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LEHMER_UNIFORM_GENERATOR_DEFINES_SVH

// The condition holds in the same cycle as the trigger
`define SLUG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition holds in the cycle after the trigger
`define SLUG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/slug_pkg.sv]
// ============================================================================
// slug_pkg
// Shared types and constants of the shuffled Lehmer uniform generator.
// ============================================================================
package slug_pkg;

    // Lehmer generator: x' = 16807 * x mod (2^31 - 1)
    localparam int          NUM_W        = 31;
    localparam int          MUL_W        = 15;
    localparam int          PROD_W       = NUM_W + MUL_W;
    localparam logic [14:0] LEHMER_MUL   = 15'd16807;
    localparam logic [30:0] LEHMER_MOD   = 31'h7FFF_FFFF;
    localparam int          WARMUP_STEPS = 8;

    // Kind of an input word
    typedef enum logic
    {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } opcode_t;

    // Shuffle table command
    typedef struct packed
    {
        logic draw;     // read-modify-write at the slot of the last output
        logic fill_we;  // write at the fill index
    } tbl_cmd_t;

endpackage

[hw/rtl/slug_lehmer.sv]
// ============================================================================
// slug_lehmer
// One Lehmer step: registered product, then Mersenne fold.
// ============================================================================
module slug_lehmer
(
    input  logic                        clk,
    input  logic [slug_pkg::NUM_W-1:0]  x,   // current state
    output logic [slug_pkg::NUM_W-1:0]  y    // next state of x from the previous cycle
);

    logic [slug_pkg::PROD_W-1:0] prod_reg;
    logic [slug_pkg::NUM_W:0]    fold;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= slug_pkg::PROD_W'(x) * slug_pkg::PROD_W'(slug_pkg::LEHMER_MUL);
    end

    // 2^31 = 1 mod (2^31 - 1): add high part to low part, one correction
    assign fold = (slug_pkg::NUM_W+1)'(prod_reg[slug_pkg::NUM_W-1:0])
                + (slug_pkg::NUM_W+1)'(prod_reg[slug_pkg::PROD_W-1:slug_pkg::NUM_W]);

    assign y = (fold >= (slug_pkg::NUM_W+1)'(slug_pkg::LEHMER_MOD))
             ? slug_pkg::NUM_W'(fold - (slug_pkg::NUM_W+1)'(slug_pkg::LEHMER_MOD))
             : fold[slug_pkg::NUM_W-1:0];

endmodule

[hw/rtl/slug_table.sv]
// ============================================================================
// slug_table
// Shuffle table memory with the slot index unit. The slot of the last output
// is last / SLOT_DIV, done as a registered reciprocal multiply.
// ============================================================================
module slug_table
#(
    parameter int TABLE_DEPTH = 32,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic                        clk,
    input  slug_pkg::tbl_cmd_t          cmd,
    input  logic [IDX_W-1:0]            fill_idx,
    input  logic [slug_pkg::NUM_W-1:0]  wr_data,
    input  logic [slug_pkg::NUM_W-1:0]  last_output,
    output logic [slug_pkg::NUM_W-1:0]  rd_data
);

    // Divisor 1 + (2^31 - 2) / depth, exact reciprocal for 31-bit dividends
    localparam longint unsigned SLOT_DIV =
        64'd1 + (64'(slug_pkg::LEHMER_MOD) - 64'd1) / 64'(TABLE_DEPTH);
    localparam int              SLOT_LOG   = $clog2(SLOT_DIV);
    localparam int              SLOT_SHIFT = slug_pkg::NUM_W + SLOT_LOG;
    localparam longint unsigned RECIP_L    =
        ((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam logic [31:0]     RECIP      = 32'(RECIP_L);
    localparam int              SP_W       = slug_pkg::NUM_W + 32;

    logic [slug_pkg::NUM_W-1:0] mem [TABLE_DEPTH];
    logic [slug_pkg::NUM_W-1:0] rd_data_reg;
    logic [SP_W-1:0]            slot_prod_reg;
    logic [SP_W-1:0]            slot_q;
    logic [IDX_W-1:0]           slot;
    logic [IDX_W-1:0]           addr;

    // Slot multiply stage
    always_ff @(posedge clk)
    begin
        slot_prod_reg <= SP_W'(last_output) * SP_W'(RECIP);
    end

    // Quotient with a clamp to the top slot as a guard
    assign slot_q = slot_prod_reg >> SLOT_SHIFT;
    assign slot   = (slot_q >= SP_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                   : slot_q[IDX_W-1:0];
    assign addr   = cmd.fill_we ? fill_idx : slot;

    // Single port, read-first: a draw returns the old entry and stores the new
    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            rd_data_reg <= mem[addr];
        end
        if (cmd.draw || cmd.fill_we)
        begin
            mem[addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/shuffled_lehmer_uniform_generator.sv]
// ============================================================================
// shuffled_lehmer_uniform_generator
// Minimal standard Lehmer generator behind a Bays-Durham shuffle table.
// ============================================================================
// A draw word runs its slot and generator multiplies in the accepting cycle,
// then the table read-modify-write, then the result register, which waits
// while the output side holds a result that is not yet taken. The input is
// taken again only once the result is in the output register, so draws do
// not overlap. A reseed word, and the first draw after reset, first run
// TABLE_DEPTH + 8 generator steps, each a multiply state and a modular fold
// state, and then a settle state (S_PREP) before the draw. The table memory
// needs no clearing: it is always filled before it is read.
module shuffled_lehmer_uniform_generator
#(
    parameter int TABLE_DEPTH   = 32,
    parameter int FRACTION_BITS = 24,
    localparam int OUT_W = ((slug_pkg::NUM_W + FRACTION_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Input words
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // [30:0] seed_value
    input  logic [0:0]       s_axis_tuser,   // [0] opcode
    // Result words
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // number, then fraction
);

`include "shuffled_lehmer_uniform_generator_defines.svh"

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_STEPS = TABLE_DEPTH + slug_pkg::WARMUP_STEPS;
    localparam int CNT_W      = $clog2(FILL_STEPS);
    localparam int NW         = slug_pkg::NUM_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FMUL,
        S_FRED,
        S_PREP,
        S_DRAW,
        S_DONE
    } state_t;

    state_t             state_reg,     state_next;
    logic [NW-1:0]      gen_reg,       gen_next;
    logic [NW-1:0]      last_reg,      last_next;
    logic               ready_reg,     ready_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [NW-1:0]      out_num_reg,   out_num_next;

    logic [NW-1:0]      step_y;
    logic [NW-1:0]      rd_data;
    logic [NW-1:0]      seed_in;
    logic [NW-1:0]      seed_fix;
    logic               in_acc;
    slug_pkg::opcode_t  opcode;
    slug_pkg::tbl_cmd_t cmd;

    // Generator step unit
    slug_lehmer u_lehmer
    (
        .clk (clk),
        .x   (gen_reg),
        .y   (step_y)
    );

    // Shuffle table
    slug_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table
    (
        .clk         (clk),
        .cmd         (cmd),
        .fill_idx    (cnt_reg[IDX_W-1:0]),
        .wr_data     (step_y),
        .last_output (last_reg),
        .rd_data     (rd_data)
    );

    // Input decode; zero and the modulus both seed as one
    assign opcode   = slug_pkg::opcode_t'(s_axis_tuser[0]);
    assign seed_in  = s_axis_tdata[NW-1:0];
    assign seed_fix = (seed_in == '0 || seed_in == slug_pkg::LEHMER_MOD) ? NW'(1) : seed_in;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        last_next      = last_reg;
        ready_next     = ready_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        cmd            = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (opcode == slug_pkg::OP_RESEED)
                    begin
                        gen_next   = seed_fix;
                        cnt_next   = CNT_W'(FILL_STEPS - 1);
                        state_next = S_FMUL;
                    end
                    else if (!ready_reg)
                    begin
                        gen_next   = NW'(1);
                        cnt_next   = CNT_W'(FILL_STEPS - 1);
                        state_next = S_FMUL;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end

            S_FMUL:
            begin
                state_next = S_FRED;
            end

            // Warm-up, then fill from the top slot down
            S_FRED:
            begin
                gen_next    = step_y;
                cmd.fill_we = (cnt_reg < CNT_W'(TABLE_DEPTH));
                if (cnt_reg == '0)
                begin
                    last_next  = step_y;
                    ready_next = 1'b1;
                    state_next = S_PREP;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_FMUL;
                end
            end

            // Let the multipliers see the fresh state
            S_PREP:
            begin
                state_next = S_DRAW;
            end

            S_DRAW:
            begin
                gen_next   = step_y;
                cmd.draw   = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    last_next      = rd_data;
                    out_num_next   = rd_data;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= NW'(1);
            last_reg      <= '0;
            ready_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_num_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            last_reg      <= last_next;
            ready_reg     <= ready_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_num_reg   <= out_num_next;
        end
    end

    // Result word: fraction is the top bits of the number
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_num_reg[NW-1 -: FRACTION_BITS], out_num_reg});

    // Checks
    `SLUG_ASSERT_SAME(a_gen_range, 1'b1, (gen_reg != '0 && gen_reg != slug_pkg::LEHMER_MOD), "generator state left 1 .. 2^31-2")
    `SLUG_ASSERT_SAME(a_draw_filled, (state_reg == S_DRAW), ready_reg, "draw on an unfilled table")
    `SLUG_ASSERT_SAME(a_fill_cnt, (state_reg == S_FMUL || state_reg == S_FRED), (cnt_reg < CNT_W'(FILL_STEPS)), "fill counter out of range")
    `SLUG_ASSERT_SAME(a_out_nonzero, m_axis_tvalid, (out_num_reg != '0), "zero number delivered")

endmodule
